FILE: hw/rtl/mte_pkg.sv
// mte_pkg: types, constants and the key-to-letter map for the multi-tap
// text entry block. No dependencies.
package mte_pkg;

    localparam int unsigned KEY_W     = 8;
    localparam int unsigned TAP_W     = 2;
    localparam int unsigned ELAPSED_W = 16;

    localparam logic [TAP_W-1:0]     TAPS_MAX      = 2'd3;
    localparam logic [ELAPSED_W-1:0] TIMEOUT_RESET = 16'd500;
    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX   = 16'hFFFF;

    typedef enum logic {
        KIND_TICK = 1'b0,
        KIND_KEY  = 1'b1
    } kind_t;

    typedef struct packed {
        kind_t            kind;
        logic [KEY_W-1:0] key_code;
    } item_t;

    // Letter committed for a key after count taps (count is 1..3).
    // Keys outside '2'..'9' pass through unchanged.
    function automatic logic [KEY_W-1:0] letter_of(
        input logic [KEY_W-1:0] key,
        input logic [TAP_W-1:0] count
    );
        logic [KEY_W-1:0] base;
        logic [KEY_W-1:0] ofs;
        logic             mapped;
        ofs    = {{(KEY_W-TAP_W){1'b0}}, count} - 8'd1;
        mapped = 1'b1;
        base   = 8'd0;
        unique case (key)
            "2":     base = "a";
            "3":     base = "d";
            "4":     base = "g";
            "5":     base = "j";
            "6":     base = "m";
            // no q on this key: first tap is p, then r and s
            "7":     base = (count == 2'd1) ? "p" : "q";
            "8":     base = "t";
            "9":     base = "w";
            default: mapped = 1'b0;
        endcase
        if (!mapped) begin
            return key;
        end
        if (key == "7" && count == 2'd1) begin
            return base;
        end
        return base + ofs;
    endfunction

endpackage

FILE: hw/rtl/multitap_text_entry_top.sv
// multitap_text_entry_top: multi-tap keypad text entry, tick and key-release
// transactions in, committed characters out. Depends on mte_pkg.
//
//  channel  | ports                      | payload
//  ---------+----------------------------+-------------------------------------
//  input    | s_tvalid s_tready s_tdata  | tdata[7:0] key_code
//           | s_tuser                    | tuser[0] kind (0 tick, 1 key release)
//  result   | m_tvalid m_tready m_tdata  | tdata[7:0] letter
//  config   | cfg_we cfg_wdata           | commit_timeout_ms, reset 500
//
// A transaction is registered at the input stage, then processed against the
// tap state into the result register, which drives m_tvalid. One transaction
// per clock is sustained while the result channel is not stalled; the update
// of pending key, tap count and idle count is a single compare-and-update step.
// Reset (aresetn low, synchronous) empties both stages, clears the tap state
// and loads the timeout with 500 ms. A stall on m_tready holds the result
// register; the input stage still fills, and s_tready drops only once both
// stages are occupied and the result is not taken.
module multitap_text_entry_top
    import mte_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // input channel
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [KEY_W-1:0]     s_tdata,   // [7:0] key_code
    input  logic                 s_tuser,   // [0] kind
    // result channel
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [KEY_W-1:0]     m_tdata,   // [7:0] letter
    // configuration
    input  logic                 cfg_we,
    input  logic [ELAPSED_W-1:0] cfg_wdata
);

    // input stage
    logic                 in_valid_reg;
    item_t                in_item_reg;
    // tap state
    logic [KEY_W-1:0]     pending_key_reg,  pending_key_next;
    logic [TAP_W-1:0]     tap_cnt_reg,      tap_cnt_next;
    logic [ELAPSED_W-1:0] elapsed_reg,      elapsed_next;
    logic [ELAPSED_W-1:0] timeout_reg;
    // result stage
    logic                 out_valid_reg;
    logic [KEY_W-1:0]     out_letter_reg,   out_letter_next;

    logic                 proc_go;    // input stage is processed this cycle
    logic                 commit;     // processing yields a character
    logic [TAP_W-1:0]     tap_inc;

    // Processing needs a free result slot (empty or being taken now).
    assign proc_go  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || proc_go;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_letter_reg;
    assign tap_inc  = tap_cnt_reg + 2'd1;

    // Tap state update for the transaction in the input stage.
    always_comb begin
        pending_key_next = pending_key_reg;
        tap_cnt_next     = tap_cnt_reg;
        elapsed_next     = elapsed_reg;
        out_letter_next  = letter_of(pending_key_reg, tap_cnt_reg);
        commit           = 1'b0;
        unique case (in_item_reg.kind)
            KIND_TICK: begin
                // saturating idle count; a timeout commit leaves it as is
                if (elapsed_reg != ELAPSED_MAX) begin
                    elapsed_next = elapsed_reg + 16'd1;
                end
                if (tap_cnt_reg != '0 && elapsed_next > timeout_reg) begin
                    commit           = 1'b1;
                    pending_key_next = '0;
                    tap_cnt_next     = '0;
                end
            end
            KIND_KEY: begin
                elapsed_next = '0;
                if (tap_cnt_reg != '0 && in_item_reg.key_code == pending_key_reg) begin
                    // same key again: third tap commits at once
                    if (tap_inc == TAPS_MAX) begin
                        commit           = 1'b1;
                        out_letter_next  = letter_of(pending_key_reg, TAPS_MAX);
                        pending_key_next = '0;
                        tap_cnt_next     = '0;
                    end else begin
                        tap_cnt_next = tap_inc;
                    end
                end else begin
                    // new key; commits whatever was pending
                    commit           = (tap_cnt_reg != '0);
                    pending_key_next = in_item_reg.key_code;
                    tap_cnt_next     = 2'd1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            pending_key_reg <= '0;
            tap_cnt_reg     <= '0;
            elapsed_reg     <= '0;
            timeout_reg     <= TIMEOUT_RESET;
        end else begin
            if (cfg_we) begin
                timeout_reg <= cfg_wdata;
            end
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
                in_item_reg  <= item_t'{kind: kind_t'(s_tuser), key_code: s_tdata};
            end else if (proc_go) begin
                in_valid_reg <= 1'b0;
            end
            if (proc_go) begin
                pending_key_reg <= pending_key_next;
                tap_cnt_reg     <= tap_cnt_next;
                elapsed_reg     <= elapsed_next;
                out_valid_reg   <= commit;
                if (commit) begin
                    out_letter_reg <= out_letter_next;
                end
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    // the third tap always commits, so a count of three never stays
    a_tap_below_max: assert property (@(posedge aclk) disable iff (!aresetn)
        tap_cnt_reg != TAPS_MAX)
        else $error("tap count reached its maximum without commit");

    // no pending key means the key register is cleared
    a_idle_key_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (tap_cnt_reg == '0) |-> (pending_key_reg == '0))
        else $error("pending key left over with no taps");

    // a character is only committed from a pending key
    a_commit_needs_key: assert property (@(posedge aclk) disable iff (!aresetn)
        (proc_go && commit) |-> (tap_cnt_reg != '0))
        else $error("commit with nothing pending");

    // a key release restarts the idle count
    a_key_clears_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (proc_go && in_item_reg.kind == KIND_KEY) |=> (elapsed_reg == '0))
        else $error("idle count not cleared by key release");
`endif

endmodule

FILE: bench/tb_multitap_text_entry_top.sv
// tb_multitap_text_entry_top: self-checking bench for multitap_text_entry_top,
// with a scoreboard that predicts committed letters from the key and tick stream.
// Depends on mte_pkg and the RTL of multitap_text_entry_top.
module tb_multitap_text_entry_top;
    import mte_pkg::*;

    // Allow margin for both stages to drain before config writes and at the end.
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int PHASE_ITEMS   = 55;
    localparam int RANDOM_PHASES = 4;

    // Predicts the letters committed by the multi-tap state and checks them in order.
    class multitap_scoreboard;
        logic [ELAPSED_W-1:0] timeout_ms;
        logic [KEY_W-1:0]     held_key;
        logic [TAP_W-1:0]     taps;
        logic [ELAPSED_W-1:0] idle_ms;
        logic [KEY_W-1:0]     expected_letters[$];
        int                   errors;

        function new();
            timeout_ms = TIMEOUT_RESET;
            held_key   = '0;
            taps       = '0;
            idle_ms    = '0;
            errors     = 0;
        endfunction

        // Character for a key after n taps (n is 1..3); unmapped keys pass through.
        function logic [KEY_W-1:0] tap_letter(logic [KEY_W-1:0] key, logic [TAP_W-1:0] n);
            string letters;
            case (key)
                "2": letters = "abc";
                "3": letters = "def";
                "4": letters = "ghi";
                "5": letters = "jkl";
                "6": letters = "mno";
                "7": letters = "prs";
                "8": letters = "tuv";
                "9": letters = "wxy";
                default: return key;
            endcase
            return letters[int'(n) - 1];
        endfunction

        // Update the tap state for one accepted transaction.
        function void note_item(kind_t item_kind, logic [KEY_W-1:0] key_code);
            if (item_kind == KIND_TICK) begin
                if (idle_ms != ELAPSED_MAX)
                    idle_ms++;
                if (taps != 0 && idle_ms > timeout_ms) begin
                    expected_letters.push_back(tap_letter(held_key, taps));
                    held_key = '0;
                    taps     = '0;
                end
                return;
            end
            idle_ms = '0;
            if (taps != 0 && key_code == held_key) begin
                taps++;
                if (taps == TAPS_MAX) begin
                    expected_letters.push_back(tap_letter(held_key, TAPS_MAX));
                    held_key = '0;
                    taps     = '0;
                end
            end else begin
                if (taps != 0)
                    expected_letters.push_back(tap_letter(held_key, taps));
                held_key = key_code;
                taps     = 2'd1;
            end
        endfunction

        task report(string what, logic [KEY_W-1:0] got, logic [KEY_W-1:0] want);
            $display("mismatch: %s, got 8'h%h, expected 8'h%h", what, got, want);
            errors++;
        endtask

        task check_letter(logic [KEY_W-1:0] got);
            logic [KEY_W-1:0] want;
            if (expected_letters.size() == 0) begin
                report("letter with nothing pending", got, '0);
            end else begin
                want = expected_letters.pop_front();
                if (got !== want)
                    report("letter", got, want);
            end
        endtask
    endclass

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [KEY_W-1:0]     s_tdata   = '0;   // [7:0] key_code
    logic                 s_tuser   = 1'b0; // [0] kind
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [KEY_W-1:0]     m_tdata;          // [7:0] letter
    logic                 cfg_we    = 1'b0;
    logic [ELAPSED_W-1:0] cfg_wdata = '0;

    multitap_scoreboard sb;
    int  cycles   = 0;
    int  rx_wait  = 0;
    bit  tx_quiet = 1'b0;   // sender inserts no gaps while set
    bit  rx_quiet = 1'b0;   // receiver never stalls while set

    multitap_text_entry_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    // Watchdog: a hung handshake or a lost letter ends the run here.
    always @(posedge aclk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Result side: sample at the rising edge, check, then draw the next stall.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_letter(m_tdata);
            rx_wait = rx_quiet ? 0 : $urandom_range(0, 14);
        end
    end

    // Ready changes only at the falling edge.
    always @(negedge aclk) begin
        if (rx_wait > 0) begin
            m_tready <= 1'b0;
            rx_wait--;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Drive one transaction after a random gap and wait for the handshake.
    // Valid is left high on return so back-to-back transactions never drop it.
    task automatic send_item(kind_t item_kind, logic [KEY_W-1:0] key_code);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 14);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= item_kind;
        s_tdata  <= key_code;
        do @(posedge aclk); while (!s_tready);
        sb.note_item(item_kind, key_code);
    endtask

    task automatic send_key(logic [KEY_W-1:0] key_code);
        send_item(KIND_KEY, key_code);
    endtask

    // Ticks carry random key_code bits, which the block must ignore.
    task automatic send_ticks(int n);
        repeat (n) send_item(KIND_TICK, KEY_W'($urandom_range(0, 255)));
    endtask

    // Quiesce: stop sending, collect every expected letter, let the pipeline
    // drain (a key or tick may still be in flight with no letter), then write.
    task automatic write_timeout(logic [ELAPSED_W-1:0] value);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.expected_letters.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        sb.timeout_ms = value;
    endtask

    // One random phase: mostly digit sequences with repeats, tick runs sized
    // around the timeout, plus pass-through and arbitrary key codes.
    task automatic random_phase(logic [ELAPSED_W-1:0] to);
        int               sent;
        int               run;
        logic [KEY_W-1:0] last_digit;
        logic [KEY_W-1:0] code;
        sent       = 0;
        last_digit = "2";
        tx_quiet   = ($urandom_range(0, 3) == 0);
        rx_quiet   = ($urandom_range(0, 3) == 0);
        while (sent < PHASE_ITEMS) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: begin
                    if ($urandom_range(0, 1) == 0)
                        last_digit = KEY_W'("2" + $urandom_range(0, 7));
                    send_key(last_digit);
                    sent++;
                end
                5: begin
                    case ($urandom_range(0, 4))
                        0: code = "0";
                        1: code = "1";
                        2: code = "*";
                        3: code = "#";
                        default: code = KEY_W'($urandom_range(0, 255));
                    endcase
                    send_key(code);
                    sent++;
                end
                default: begin
                    run = $urandom_range(1, (to > 40) ? 43 : int'(to) + 3);
                    send_ticks(run);
                    sent += run;
                end
            endcase
        end
    endtask

    initial begin
        sb = new();
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: nothing pending, third-tap commit, key changes, the 7 key,
        // key code zero, pass-through keys, all at the reset timeout of 500 ms.
        send_ticks(1);
        send_key("2"); send_key("2"); send_key("2");        // c
        send_key("7"); send_key("7"); send_key("8");        // r
        send_key("9");                                      // t
        send_key(8'h00);                                    // w
        send_key(8'h00); send_key(8'h00);                   // 0x00 after three taps
        send_key(8'hFF); send_key("*");                     // 0xFF
        send_key("#"); send_key("1"); send_key("0");        // * # 1
        send_key("7"); send_key("3");                       // 0, then p
        send_key("4"); send_key("4"); send_key("5");        // d, h
        send_key("6"); send_key("6"); send_key("6");        // j, o
        // Idle exactly to the timeout, then one more tick commits.
        tx_quiet = 1'b1;
        send_key("8");
        send_ticks(501);
        tx_quiet = 1'b0;

        // Smallest timeout: second tick after a tap commits.
        write_timeout(16'd1);
        send_key("5"); send_key("5");
        send_ticks(3);

        // Zero timeout: the first tick after a tap commits.
        write_timeout(16'd0);
        send_key("8");
        send_ticks(2);

        // Largest timeout: a short idle run commits nothing.
        write_timeout(ELAPSED_MAX);
        tx_quiet = 1'b1;
        send_key("4");
        send_ticks(40);
        tx_quiet = 1'b0;
        send_key("4"); send_key("3");                       // h

        // Random phases, each with its own timeout, small ones mostly.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            if ($urandom_range(0, 3) == 0)
                write_timeout(ELAPSED_W'($urandom_range(0, 3)));
            else
                write_timeout(ELAPSED_W'($urandom_range(4, 40)));
            random_phase(sb.timeout_ms);
        end

        // Drain: lower valid, collect every letter, then watch for strays.
        @(negedge aclk);
        s_tvalid <= 1'b0;
        rx_quiet = 1'b0;
        while (sb.expected_letters.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/mte_pkg.sv
hw/rtl/multitap_text_entry_top.sv
bench/tb_multitap_text_entry_top.sv
